[hw/rtl/tpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types and constants of the three-axis step pulse generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RateW    = 16;
  localparam int unsigned MagW     = CoordW + 1;
  localparam int unsigned ProdW    = MagW + RateW;
  localparam int unsigned Axes     = 3;
  localparam int unsigned QueueCnt = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_DIR  = 2'd0,
    KIND_STEP = 2'd1,
    KIND_REST = 2'd2,
    KIND_IDLE = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  bit_x;
    logic  bit_y;
    logic  bit_z;
    logic  last;
    logic  seg_end;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

[hw/rtl/tpg_axis_plan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_axis_plan
// Per-axis planning pipe: direction and magnitude, then pulse count product.
// ----------------------------------------------------------------------------
module tpg_axis_plan #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [tpg_pkg::CoordW-1:0] start_i,
  input  logic signed [tpg_pkg::CoordW-1:0] end_i,
  input  logic [tpg_pkg::RateW-1:0]       rate_i,
  output logic                            dir_o,
  output logic [COUNT_BITS-1:0]           count_o
);

  localparam int unsigned MagW  = tpg_pkg::MagW;
  localparam int unsigned ProdW = tpg_pkg::ProdW;
  localparam logic [ProdW-1:0] CntMax = ProdW'((64'd1 << COUNT_BITS) - 64'd1);

  logic signed [MagW-1:0] fwd, bwd;
  logic                   dir_d;
  logic [MagW-1:0]        mag_d;
  logic                   dir1_q, dir2_q;
  logic [MagW-1:0]        mag_q;
  logic [tpg_pkg::RateW-1:0] rate_q;
  logic [ProdW-1:0]       prod_q;
  logic [ProdW-1:0]       shifted;

  // both differences in parallel, pick the non-negative one
  assign fwd   = MagW'(end_i) - MagW'(start_i);
  assign bwd   = MagW'(start_i) - MagW'(end_i);
  assign dir_d = !fwd[MagW-1] && (fwd != '0);
  assign mag_d = fwd[MagW-1] ? bwd : fwd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir1_q <= dir_d;
      mag_q  <= mag_d;
      rate_q <= rate_i;
      dir2_q <= dir1_q;
      prod_q <= ProdW'(rate_q) * ProdW'(mag_q);
    end
  end

  assign shifted = prod_q >> FRAC_BITS;
  assign count_o = (shifted > CntMax) ? '1 : shifted[COUNT_BITS-1:0];
  assign dir_o   = dir2_q;

endmodule

[hw/rtl/tpg_slot_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_slot_engine
// Segment state and per-slot pulse decisions, one item per cycle on fire_i.
// ----------------------------------------------------------------------------
module tpg_slot_engine #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  tpg_pkg::op_e          op_i,
  input  logic [2:0]            dir_i,
  input  logic [COUNT_BITS-1:0] count_i [tpg_pkg::Axes],
  output tpg_pkg::push_t        push_o
);

  localparam int unsigned CB = COUNT_BITS;

  logic [CB-1:0] slot_q, slot_d;
  logic [CB-1:0] longest_q, longest_d;
  logic [CB-1:0] counts_q [tpg_pkg::Axes];
  logic [CB-1:0] counts_d [tpg_pkg::Axes];
  logic [CB-1:0] rems_q [tpg_pkg::Axes];
  logic [CB-1:0] rems_d [tpg_pkg::Axes];
  logic          active_q, active_d;

  logic [CB-1:0] most_xy, most;
  logic [CB:0]   sum [tpg_pkg::Axes];
  logic [CB+1:0] wrap [tpg_pkg::Axes];
  logic [2:0]    pulse;
  logic          mid_slot, final_slot;

  assign most_xy    = (count_i[1] > count_i[0]) ? count_i[1] : count_i[0];
  assign most       = (count_i[2] > most_xy) ? count_i[2] : most_xy;
  assign mid_slot   = (slot_q == (longest_q >> 1));
  assign final_slot = ((CB+1)'(slot_q) + 1'b1) == (CB+1)'(longest_q);

  always_comb begin
    for (int a = 0; a < tpg_pkg::Axes; a++) begin
      sum[a]  = (CB+1)'(rems_q[a]) + (CB+1)'(counts_q[a]);
      wrap[a] = (CB+2)'(rems_q[a]) + (CB+2)'(counts_q[a]) - (CB+2)'(longest_q);
      if (counts_q[a] == '0) begin
        pulse[a] = 1'b0;
      end else if (counts_q[a] == CB'(1)) begin
        pulse[a] = mid_slot;
      end else begin
        pulse[a] = (rems_q[a] < counts_q[a]);
      end
    end
  end

  always_comb begin
    slot_d    = slot_q;
    longest_d = longest_q;
    active_d  = active_q;
    counts_d  = counts_q;
    rems_d    = rems_q;
    push_o    = '0;
    if (op_i == tpg_pkg::OP_LOAD) begin
      push_o.num          = 2'd1;
      push_o.first.kind   = tpg_pkg::KIND_DIR;
      push_o.first.bit_x  = dir_i[0];
      push_o.first.bit_y  = dir_i[1];
      push_o.first.bit_z  = dir_i[2];
      push_o.first.last   = 1'b1;
      if (fire_i) begin
        counts_d  = count_i;
        for (int a = 0; a < tpg_pkg::Axes; a++) begin
          rems_d[a] = '0;
        end
        longest_d = most;
        slot_d    = '0;
        active_d  = (most != '0);
      end
    end else if (!active_q || longest_q == '0) begin
      push_o.num        = 2'd1;
      push_o.first.kind = tpg_pkg::KIND_IDLE;
      push_o.first.last = 1'b1;
      if (fire_i) begin
        active_d = 1'b0;
      end
    end else begin
      push_o.num            = 2'd2;
      push_o.first.kind     = tpg_pkg::KIND_STEP;
      push_o.first.bit_x    = pulse[0];
      push_o.first.bit_y    = pulse[1];
      push_o.first.bit_z    = pulse[2];
      push_o.second.kind    = tpg_pkg::KIND_REST;
      push_o.second.last    = 1'b1;
      push_o.second.seg_end = final_slot;
      if (fire_i) begin
        for (int a = 0; a < tpg_pkg::Axes; a++) begin
          rems_d[a] = wrap[a][CB+1] ? sum[a][CB-1:0] : wrap[a][CB-1:0];
        end
        slot_d   = final_slot ? '0 : slot_q + 1'b1;
        active_d = !final_slot;
      end
    end
    if (!fire_i) begin
      push_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      longest_q <= '0;
      active_q  <= 1'b0;
      for (int a = 0; a < tpg_pkg::Axes; a++) begin
        counts_q[a] <= '0;
        rems_q[a]   <= '0;
      end
    end else begin
      slot_q    <= slot_d;
      longest_q <= longest_d;
      active_q  <= active_d;
      counts_q  <= counts_d;
      rems_q    <= rems_d;
    end
  end

endmodule

[hw/rtl/tpg_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_out_queue
// Three-entry result queue, up to two pushes and one transfer per cycle.
// ----------------------------------------------------------------------------
module tpg_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tpg_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output tpg_pkg::res_t  head_o
);

  localparam int unsigned Depth = 3;

  tpg_pkg::res_t q_q [Depth];
  tpg_pkg::res_t q_d [Depth];
  logic [tpg_pkg::QueueCnt-1:0] cnt_q, cnt_d, cnt_p;
  logic pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign cnt_p   = cnt_q - tpg_pkg::QueueCnt'(pop);
  assign room_o  = (cnt_p <= 2'd1);
  assign head_o  = q_q[0];

  always_comb begin
    q_d = q_q;
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        q_d[i] = q_q[i+1];
      end
    end
    for (int i = 0; i < Depth; i++) begin
      if (push_i.num != 2'd0 && cnt_p == 2'(i)) begin
        q_d[i] = push_i.first;
      end
      if (push_i.num == 2'd2 && (cnt_p + 2'd1) == 2'(i)) begin
        q_d[i] = push_i.second;
      end
    end
    cnt_d = cnt_p + push_i.num;
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/three_axis_step_pulse_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_step_pulse_generator
// Plans one three-axis straight move and plays it as step pulse slots.
// ----------------------------------------------------------------------------
// Input stream: tuser selects a load (0) or a slot tick (1); tdata carries the
// start and end points and per-axis rates. A load answers with one direction
// result; a tick answers with a step pattern and a rest result, or with one
// idle result when no move is active.
// Output stream: tuser is the result kind, tdata the axis bits and the
// segment end flag, tlast marks the final result of an input item.
// An item's first result passes the input register, the magnitude stage, the
// multiply stage and the commit into the queue before it is presented.
// Input: one transfer per cycle while tready is high; a tick yields two
// results, so a run of ticks is limited by the single output port.
// The 16 x 33 bit multiply in each axis sets the pipeline depth.
// Reset clears the pipe, the queue and the move state (no move active).
// When the receiver stalls, the three-entry result queue fills and tready
// drops until room for a full tick answer frees up.
// ----------------------------------------------------------------------------
module three_axis_step_pulse_generator #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // start_x, start_y, start_z, end_x, end_y, end_z, rate_x, rate_y, rate_z
  input  logic [239:0] s_axis_tdata_i,
  // op
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // bit_x, bit_y, bit_z, segment_end, zero padding
  output logic [7:0]   m_axis_tdata_o,
  // kind
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  localparam int unsigned CW = tpg_pkg::CoordW;
  localparam int unsigned RW = tpg_pkg::RateW;

  logic            v0_q, v1_q, v2_q;
  tpg_pkg::op_e    op0_q, op1_q, op2_q;
  logic [239:0]    data_q;
  logic            en, room, fire;
  logic [2:0]      dir;
  logic [COUNT_BITS-1:0] count [tpg_pkg::Axes];
  tpg_pkg::push_t  push;
  tpg_pkg::res_t   head;

  assign en              = !v2_q || room;
  assign fire            = v2_q && room;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= s_axis_tdata_i;
      op0_q  <= tpg_pkg::op_e'(s_axis_tuser_i);
      op1_q  <= op0_q;
      op2_q  <= op1_q;
    end
  end

  for (genvar a = 0; a < tpg_pkg::Axes; a++) begin : g_axis
    tpg_axis_plan #(
      .COUNT_BITS(COUNT_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_plan (
      .clk_i  (clk_i),
      .en_i   (en),
      .start_i(data_q[a*CW +: CW]),
      .end_i  (data_q[(a+3)*CW +: CW]),
      .rate_i (data_q[6*CW + a*RW +: RW]),
      .dir_o  (dir[a]),
      .count_o(count[a])
    );
  end

  tpg_slot_engine #(
    .COUNT_BITS(COUNT_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (op2_q),
    .dir_i  (dir),
    .count_i(count),
    .push_o (push)
  );

  tpg_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .head_o (head)
  );

  assign m_axis_tdata_o = {4'b0000, head.seg_end, head.bit_z, head.bit_y, head.bit_x};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

[test/three_axis_step_pulse_generator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_step_pulse_generator_test
// Self-checking bench for the three-axis step pulse generator.
// ----------------------------------------------------------------------------
// A queue of load and tick transfers is built up front: a directed opening
// (idle ticks, empty and saturated moves, single-pulse axes, a load that
// replaces a running move) followed by random moves that are mostly played
// out to their last slot. A bit-exact predictor of the move planner and slot
// player runs on every accepted input transfer and keeps the results due.
// Both sides of the stream stall at random, the receiver also holds off once
// for a long stretch so that the result queue fills and tready drops.
// ----------------------------------------------------------------------------
module three_axis_step_pulse_generator_test;

  localparam int unsigned CountBits = 24;
  localparam int unsigned FracBits  = 16;
  localparam longint      MaxCount  = (64'd1 << CountBits) - 1;
  localparam int          NumItems  = 750;
  localparam int          StallLimit = 3000;
  localparam int          HoldCycles = 200;

  typedef struct {
    tpg_pkg::op_e     op;
    logic [2:0][31:0] from_pt;
    logic [2:0][31:0] to_pt;
    logic [2:0][15:0] rate;
  } move_item_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [239:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  three_axis_step_pulse_generator #(
    .COUNT_BITS(CountBits),
    .FRAC_BITS (FracBits)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  move_item_t     pending_moves[$];
  tpg_pkg::res_t  due_results[$];
  move_item_t     offered;
  int         errors = 0;
  int         inputs_sent = 0;
  int         results_seen = 0;
  int         stall_cycles = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  // move state mirrored from the block
  logic [23:0]      slot_idx = '0;
  logic [23:0]      longest = '0;
  logic [2:0][23:0] axis_cnt = '0;
  logic [2:0][23:0] axis_rem = '0;
  bit               moving = 1'b0;

  function automatic tpg_pkg::res_t make_res(tpg_pkg::kind_e k, logic [2:0] b, logic l,
                                             logic e);
    tpg_pkg::res_t r;
    r.kind    = k;
    r.bit_x   = b[0];
    r.bit_y   = b[1];
    r.bit_z   = b[2];
    r.last    = l;
    r.seg_end = e;
    return r;
  endfunction

  task automatic advance_move(input move_item_t it);
    longint      s;
    longint      e;
    longint      mag;
    longint      cnt;
    logic [23:0] most;
    logic [2:0]  dir;
    logic [2:0]  pulse;
    logic [24:0] acc;
    logic        fin;
    if (it.op == tpg_pkg::OP_LOAD) begin
      most = '0;
      for (int a = 0; a < 3; a++) begin
        s = $signed(it.from_pt[a]);
        e = $signed(it.to_pt[a]);
        dir[a] = (e > s);
        mag = (e > s) ? e - s : s - e;
        cnt = (longint'(it.rate[a]) * mag) >> FracBits;
        if (cnt > MaxCount) cnt = MaxCount;
        axis_cnt[a] = cnt[23:0];
        axis_rem[a] = '0;
        if (axis_cnt[a] > most) most = axis_cnt[a];
      end
      longest  = most;
      slot_idx = '0;
      moving   = (most != 0);
      due_results = {due_results, make_res(tpg_pkg::KIND_DIR, dir, 1'b1, 1'b0)};
    end else if (!moving || longest == 0) begin
      moving = 1'b0;
      due_results = {due_results, make_res(tpg_pkg::KIND_IDLE, 3'b000, 1'b1, 1'b0)};
    end else begin
      for (int a = 0; a < 3; a++) begin
        if (axis_cnt[a] == 0) pulse[a] = 1'b0;
        else if (axis_cnt[a] == 1) pulse[a] = (slot_idx == longest / 2);
        else pulse[a] = (axis_rem[a] < axis_cnt[a]);
        acc = {1'b0, axis_rem[a]} + {1'b0, axis_cnt[a]};
        if (acc >= {1'b0, longest}) acc = acc - {1'b0, longest};
        axis_rem[a] = acc[23:0];
      end
      fin = ({1'b0, slot_idx} + 25'd1 == {1'b0, longest});
      due_results = {due_results, make_res(tpg_pkg::KIND_STEP, pulse, 1'b0, 1'b0)};
      due_results = {due_results, make_res(tpg_pkg::KIND_REST, 3'b000, 1'b1, fin)};
      slot_idx = slot_idx + 24'd1;
      if (fin) begin
        moving   = 1'b0;
        slot_idx = '0;
      end
    end
  endtask

  task automatic add_load(input logic [2:0][31:0] f, input logic [2:0][31:0] t,
                          input logic [2:0][15:0] r);
    move_item_t it;
    it.op      = tpg_pkg::OP_LOAD;
    it.from_pt = f;
    it.to_pt   = t;
    it.rate    = r;
    pending_moves = {pending_moves, it};
  endtask

  task automatic add_ticks(input int n);
    move_item_t it;
    it.op = tpg_pkg::OP_TICK;
    repeat (n) begin
      it.from_pt = {$urandom, $urandom, $urandom};
      it.to_pt   = {$urandom, $urandom, $urandom};
      it.rate    = {16'($urandom), 16'($urandom), 16'($urandom)};
      pending_moves = {pending_moves, it};
    end
  endtask

  // load with exactly the per-axis pulse counts given (zero-rate axes get none)
  task automatic add_counted_load(input int c0, input int c1, input int c2,
                                  input logic [2:0][15:0] r);
    logic [2:0][31:0] f;
    logic [2:0][31:0] t;
    longint           mag;
    int               c[3];
    c = '{c0, c1, c2};
    for (int a = 0; a < 3; a++) begin
      if (r[a] == 0) mag = $urandom_range(0, 2000000);
      else if (c[a] == 0) mag = $urandom_range(0, 65535 / r[a]);
      else mag = (longint'(c[a]) * 65536 + r[a] - 1) / r[a];
      // start well inside the signed range so the move never wraps
      f[a] = {($urandom_range(0, 1) ? 2'b00 : 2'b11), 30'($urandom)};
      t[a] = $urandom_range(0, 1) ? f[a] + mag[31:0] : f[a] - mag[31:0];
    end
    add_load(f, t, r);
  endtask

  function automatic logic [15:0] pick_rate();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return 16'($urandom_range(1, 65535));
    if (roll < 80) return 16'($urandom_range(1, 16));
    if (roll < 90) return 16'd0;
    return 16'hffff;
  endfunction

  function automatic int pick_count();
    if ($urandom_range(99) < 15) return 1;
    return $urandom_range(0, 24);
  endfunction

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_move(offered);
        inputs_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_moves.size() != 0 &&
            ((inputs_sent >= 400 && inputs_sent < 550) || $urandom_range(99) >= 15)) begin
          offered = pending_moves.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= offered.op;
          s_axis_tdata  <= {offered.rate, offered.to_pt, offered.from_pt};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    tpg_pkg::res_t got;
    tpg_pkg::res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got = make_res(tpg_pkg::kind_e'(m_axis_tuser), m_axis_tdata[2:0], m_axis_tlast,
                       m_axis_tdata[3]);
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 20)
            $display("%0t: unexpected result transfer kind %0d tdata %h last %0b",
                     $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end else begin
          want = due_results.pop_front();
          if (got !== want || m_axis_tdata[7:4] !== 4'b0000) begin
            errors++;
            if (errors <= 20)
              $display({"%0t: mismatch expected kind %0d xyz %b%b%b last %b end %b pad 0,",
                        " actual kind %0d xyz %b%b%b last %b end %b pad %h"},
                       $time, want.kind, want.bit_x, want.bit_y, want.bit_z, want.last,
                       want.seg_end, got.kind, got.bit_x, got.bit_y, got.bit_z, got.last,
                       got.seg_end, m_axis_tdata[7:4]);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 250) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (results_seen >= 600 && results_seen < 900) ||
                         $urandom_range(99) >= 15;
      end
    end
  end

  // watchdog on cycles with work outstanding but no transfer
  always @(negedge clk_i) begin
    if ((pending_moves.size() != 0 || s_axis_tvalid || due_results.size() != 0) &&
        !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
      stall_cycles++;
    else
      stall_cycles = 0;
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int c0;
    int c1;
    int c2;
    int most;
    int roll;
    // tick with no move, then an empty move
    add_ticks(1);
    add_load('0, '0, {16'hffff, 16'hffff, 16'hffff});
    add_ticks(1);
    // full-range moves saturate the count, both directions
    add_load({3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {3{16'hffff}});
    add_ticks(2);
    add_load({3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {3{16'hffff}});
    add_ticks(1);
    // equal coordinates at full rate
    add_load({3{32'h7fff_ffff}}, {3{32'h7fff_ffff}}, {3{16'hffff}});
    add_ticks(1);
    // single-pulse and silent axes, played past the end
    add_counted_load(5, 1, 0, {3{16'd1}});
    add_ticks(6);
    add_counted_load(1, 0, 0, {3{16'd1}});
    add_ticks(1);
    // a load replaces a running move
    add_counted_load(4, 4, 2, {3{16'd1}});
    add_ticks(2);
    add_counted_load(3, 0, 3, {3{16'd1}});
    add_ticks(3);

    while (pending_moves.size() < NumItems) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        c0 = pick_count();
        c1 = pick_count();
        c2 = pick_count();
        most = (c0 > c1) ? c0 : c1;
        most = (c2 > most) ? c2 : most;
        add_counted_load(c0, c1, c2, {pick_rate(), pick_rate(), pick_rate()});
        if ($urandom_range(99) < 10) add_ticks($urandom_range(0, most));
        else add_ticks(most + $urandom_range(0, 2));
      end else if (roll < 85) begin
        add_ticks(1);
      end else if (roll < 92) begin
        c0 = $urandom;
        c1 = $urandom;
        c2 = $urandom;
        add_load({c2, c1, c0}, {c2, c1, c0},
                 {16'($urandom), 16'($urandom), 16'($urandom)});
        add_ticks($urandom_range(0, 1));
      end else begin
        add_load({$urandom, $urandom, $urandom}, {$urandom, $urandom, $urandom},
                 {16'($urandom), 16'($urandom), 16'($urandom)});
        add_ticks($urandom_range(0, 3));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_moves.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (12) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
